FILE: src/sai_pkg.sv
package sai_pkg;

   localparam int CAPACITY_DEF = 64;

   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 6;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
   localparam logic [OP_W-1:0] OP_APPEND  = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT  = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE  = 3'd3;
   localparam logic [OP_W-1:0] OP_SEARCH  = 3'd4;
   localparam logic [OP_W-1:0] OP_DISPLAY = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic               load;
      logic               run;
      logic               match;
      logic               emit_search;
      logic               emit_empty;
      logic               emit_disp;
      logic               disp_last;
      logic [INDEX_W-1:0] disp_idx;
   } sai_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic               empty;
      logic               out_free;
      logic [COUNT_W-1:0] count;
   } sai_stat_type;

endpackage

FILE: src/sai_req_if.sv
interface sai_req_if import sai_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           operation;
   logic signed [VALUE_W-1:0] item_value;
   logic [INDEX_W-1:0]        item_index;

   modport source (output valid, output operation, output item_value, output item_index,
                   input ready);
   modport sink   (input valid, input operation, input item_value, input item_index,
                   output ready);
endinterface

FILE: src/sai_rsp_if.sv
interface sai_rsp_if import sai_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] out_value;
   logic [INDEX_W-1:0]        out_index;
   logic                      found;
   logic [STATUS_W-1:0]       status;
   logic [COUNT_W-1:0]        entry_count;
   logic                      last;

   modport source (output valid, output out_value, output out_index, output found,
                   output status, output entry_count, output last, input ready);
   modport sink   (input valid, input out_value, input out_index, input found,
                   input status, input entry_count, input last, output ready);
endinterface

FILE: src/sai_ctrl.sv
module sai_ctrl import sai_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  sai_stat_type stat,
   output sai_cmd_type  cmd
);

   localparam int IDX_W = $clog2(CAPACITY);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SRCH = 2'd2;
   localparam logic [1:0] S_DISP = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             disp_last;

   assign req_ready = (state_ff == S_IDLE);
   assign disp_last = (COUNT_W'(idx_ff) + COUNT_W'(1)) == stat.count;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd          = '0;
      cmd.disp_idx = INDEX_W'(idx_ff);
      cmd.disp_last = disp_last;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.match = 1'b1;
            case (stat.op)
               OP_CLEAR, OP_APPEND, OP_INSERT, OP_DELETE: begin
                  if (stat.out_free) begin
                     cmd.run  = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               OP_SEARCH: begin
                  state_in = S_SRCH;
               end
               OP_DISPLAY: begin
                  if (stat.empty) begin
                     if (stat.out_free) begin
                        cmd.emit_empty = 1'b1;
                        state_in       = S_IDLE;
                     end
                  end else begin
                     idx_in   = '0;
                     state_in = S_DISP;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SRCH: begin
            if (stat.out_free) begin
               cmd.emit_search = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_DISP: begin
            if (stat.out_free) begin
               cmd.emit_disp = 1'b1;
               idx_in        = idx_ff + IDX_W'(1);
               if (disp_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   a_one_result_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.run, cmd.emit_search, cmd.emit_empty, cmd.emit_disp}))
      else $error("more than one result command in a cycle");

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.run || cmd.emit_search || cmd.emit_empty || cmd.emit_disp) |-> stat.out_free)
      else $error("result issued while output register is held");

   a_disp_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DISP) |-> (COUNT_W'(idx_ff) < stat.count))
      else $error("display index past entry count");

endmodule

FILE: src/sai_dp.sv
module sai_dp import sai_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sai_cmd_type               cmd,
   output sai_stat_type              stat,
   input  logic [OP_W-1:0]           req_operation,
   input  logic signed [VALUE_W-1:0] req_item_value,
   input  logic [INDEX_W-1:0]        req_item_index,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic signed [VALUE_W-1:0] rsp_out_value,
   output logic [INDEX_W-1:0]        rsp_out_index,
   output logic                      rsp_found,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [COUNT_W-1:0]        rsp_entry_count,
   output logic                      rsp_last
);

   localparam int IDX_W = $clog2(CAPACITY);

   logic [OP_W-1:0]           op_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [INDEX_W-1:0]        index_ff;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic signed [VALUE_W-1:0] cells_ff [CAPACITY];
   logic signed [VALUE_W-1:0] cell_in  [CAPACITY];
   logic [CAPACITY-1:0]       match_ff, match_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] out_value_ff;
   logic [INDEX_W-1:0]        out_index_ff;
   logic                      found_ff;
   logic [STATUS_W-1:0]       status_ff;
   logic [COUNT_W-1:0]        entry_count_ff;
   logic                      last_ff;

   logic [COUNT_W-1:0]  pos;
   logic [COUNT_W-1:0]  del_pos;
   logic                full;
   logic [STATUS_W-1:0] ins_st, del_st, run_st;
   logic                do_ins, do_del, do_clr, out_load;
   logic [IDX_W-1:0]    hit_idx;

   assign pos     = (op_ff == OP_APPEND) ? count_ff : COUNT_W'(index_ff);
   assign del_pos = COUNT_W'(index_ff);
   assign full    = count_ff >= COUNT_W'(CAPACITY);
   assign ins_st  = full ? ST_FULL : ((pos > count_ff) ? ST_RANGE : ST_OK);
   assign del_st  = (del_pos >= count_ff) ? ST_RANGE : ST_OK;

   always_comb begin
      case (op_ff)
         OP_APPEND, OP_INSERT: run_st = ins_st;
         OP_DELETE:            run_st = del_st;
         default:              run_st = ST_OK;
      endcase
   end

   assign do_ins = cmd.run && ((op_ff == OP_APPEND) || (op_ff == OP_INSERT)) && (ins_st == ST_OK);
   assign do_del = cmd.run && (op_ff == OP_DELETE) && (del_st == ST_OK);
   assign do_clr = cmd.run && (op_ff == OP_CLEAR);

   always_comb begin
      count_in = count_ff;
      if (do_clr) begin
         count_in = '0;
      end else if (do_ins) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_del) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   // per-cell shift: insert moves up, delete moves down, display rotates left
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam int LO = (i == 0) ? 0 : i - 1;
      localparam int HI = (i == CAPACITY - 1) ? i : i + 1;

      always_comb begin
         cell_in[i] = cells_ff[i];
         if (do_ins) begin
            if (COUNT_W'(i) == pos) begin
               cell_in[i] = value_ff;
            end else if (COUNT_W'(i) > pos) begin
               cell_in[i] = cells_ff[LO];
            end
         end else if (do_del) begin
            if (COUNT_W'(i) >= del_pos) begin
               cell_in[i] = cells_ff[HI];
            end
         end else if (cmd.emit_disp) begin
            if (COUNT_W'(i + 1) == count_ff) begin
               cell_in[i] = cells_ff[0];
            end else if (COUNT_W'(i + 1) < count_ff) begin
               cell_in[i] = cells_ff[HI];
            end
         end
      end

      assign match_in[i] = (cells_ff[i] == value_ff) && (COUNT_W'(i) < count_ff);
   end

   always_comb begin
      hit_idx = '0;
      for (int k = CAPACITY - 1; k >= 0; k--) begin
         if (match_ff[k]) begin
            hit_idx = IDX_W'(k);
         end
      end
   end

   assign out_load = cmd.run || cmd.emit_search || cmd.emit_empty || cmd.emit_disp;

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_operation;
         value_ff <= req_item_value;
         index_ff <= req_item_index;
      end
      if (cmd.match) begin
         match_ff <= match_in;
      end
      cells_ff <= cell_in;
      if (out_load) begin
         out_value_ff   <= cmd.emit_disp ? cells_ff[0] : '0;
         out_index_ff   <= cmd.emit_search ? INDEX_W'(hit_idx) :
                           (cmd.emit_disp ? cmd.disp_idx : '0);
         found_ff       <= cmd.emit_search && (|match_ff);
         status_ff      <= cmd.run ? run_st : (cmd.emit_empty ? ST_EMPTY : ST_OK);
         entry_count_ff <= count_in;
         last_ff        <= cmd.emit_disp ? cmd.disp_last : 1'b1;
      end
   end

   assign stat.op       = op_ff;
   assign stat.empty    = (count_ff == '0);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign stat.count    = count_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = out_value_ff;
   assign rsp_out_index   = out_index_ff;
   assign rsp_found       = found_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = entry_count_ff;
   assign rsp_last        = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

endmodule

FILE: src/shift_array_insert_delete_search.sv
// Ordered array of signed 32-bit entries with clear, append, insert, delete,
// search and display operations.
// req_ch carries one operation per item (valid/ready); rsp_ch returns the
// results (valid/ready), each with the entry count after the operation.
// Clear, append, insert, delete and search give one result with last set;
// display gives one result per entry, last set on the final one, or a single
// empty-status result when nothing is held. Codes 6 and 7 give no result.
// Clear/append/insert/delete and an empty display give their result from the
// execute state; search registers the compare row, then priority encodes it;
// display gives one entry per cycle while the receiver takes each result.
// One item is in flight at a time: the next item is taken only once the
// control sequencer is back in idle after the previous one; insert/delete
// shift every cell at once. Reset clears the entry count and the result
// valid flag; cell contents and result data are not cleared. A stalled
// receiver holds the result register; an item can still be accepted and
// waits in the sequencer until the register frees.
module shift_array_insert_delete_search import sai_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sai_req_if.sink     req_ch,
   sai_rsp_if.source   rsp_ch
);

   sai_cmd_type  cmd;
   sai_stat_type stat;

   sai_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sai_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_operation   (req_ch.operation),
      .req_item_value  (req_ch.item_value),
      .req_item_index  (req_ch.item_index),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_out_value   (rsp_ch.out_value),
      .rsp_out_index   (rsp_ch.out_index),
      .rsp_found       (rsp_ch.found),
      .rsp_status      (rsp_ch.status),
      .rsp_entry_count (rsp_ch.entry_count),
      .rsp_last        (rsp_ch.last)
   );

endmodule
